>>> src/box_table_point_hit_test_unit_macros.svh
// Assertion macros for the box table point hit test unit.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef BOX_TABLE_POINT_HIT_TEST_UNIT_MACROS_SVH
`define BOX_TABLE_POINT_HIT_TEST_UNIT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked out of reset
`define BTHIT_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bthit assertion failed");

// Next-cycle implication, checked out of reset
`define BTHIT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bthit assertion failed");

`else

`define BTHIT_ASSERT_NOW(label, clk, rstn, ante, cons)
`define BTHIT_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

>>> src/bthit_pkg.sv
// Shared types and codes for the box table point hit test unit.
// No dependencies; imported by every module of the block.
package bthit_pkg;

    localparam int FUNC_W     = 2;
    localparam int ID_W       = 16;
    localparam int IN_COORD_W = 32;

    // Operation codes; code three is unused and ignored
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CHECK  = 2'd2;

    // Control part of the token that walks the cell chain
    typedef struct packed {
        logic              valid;
        logic [FUNC_W-1:0] func;
        logic              hit;      // id match (add/remove) or point inside (check)
        logic              claimed;  // a free cell took the new rectangle
    } tok_ctl_t;

    // Broadcast from the chain end to every cell
    typedef struct packed {
        logic done;    // token left the last cell this cycle
        logic commit;  // turn the pending entry into a valid one
    } bcast_t;

    // One result item
    typedef struct packed {
        logic flag;
        logic full;
    } res_t;

endpackage

>>> src/bthit_cell.sv
// One table entry of the box table point hit test chain.
// Depends on bthit_pkg; instantiated once per entry by the top level.
`include "box_table_point_hit_test_unit_macros.svh"

module bthit_cell #(
    parameter int COORD_BITS = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  bthit_pkg::tok_ctl_t       tok_in,
    input  logic [15:0]               id_in,
    input  logic signed [COORD_BITS-1:0] ax_in,
    input  logic signed [COORD_BITS-1:0] az_in,
    input  logic signed [COORD_BITS:0]   bx_in,
    input  logic signed [COORD_BITS:0]   bz_in,
    input  bthit_pkg::bcast_t         bcast,
    output bthit_pkg::tok_ctl_t       tok_out,
    output logic [15:0]               id_out,
    output logic signed [COORD_BITS-1:0] ax_out,
    output logic signed [COORD_BITS-1:0] az_out,
    output logic signed [COORD_BITS:0]   bx_out,
    output logic signed [COORD_BITS:0]   bz_out
);
    import bthit_pkg::*;

    logic                         valid_reg, valid_next;
    logic                         pend_reg, pend_next;
    logic [ID_W-1:0]              id_reg;
    logic signed [COORD_BITS-1:0] left_x_reg, near_z_reg;
    logic signed [COORD_BITS:0]   right_x_reg, far_z_reg;

    tok_ctl_t                     tok_reg, tok_next;
    logic [ID_W-1:0]              id_o_reg;
    logic signed [COORD_BITS-1:0] ax_o_reg, az_o_reg;
    logic signed [COORD_BITS:0]   bx_o_reg, bz_o_reg;

    logic                         id_match, pt_hit, capture;
    logic signed [COORD_BITS:0]   px_wide, pz_wide;

    // Compare the passing token against this entry
    assign px_wide  = {ax_in[COORD_BITS-1], ax_in};
    assign pz_wide  = {az_in[COORD_BITS-1], az_in};
    assign id_match = valid_reg && (id_reg == id_in);
    assign pt_hit   = valid_reg && (left_x_reg < ax_in) && (right_x_reg > px_wide) &&
                      (near_z_reg < az_in) && (far_z_reg > pz_wide);

    // Update the entry and the token
    always_comb begin
        tok_next   = tok_in;
        valid_next = valid_reg;
        pend_next  = pend_reg;
        capture    = 1'b0;
        if (tok_in.valid) begin
            unique case (tok_in.func)
                FUNC_ADD: begin
                    if (id_match) begin
                        tok_next.hit = 1'b1;
                    end
                    if (!valid_reg && !pend_reg && !tok_in.claimed) begin
                        tok_next.claimed = 1'b1;
                        pend_next        = 1'b1;
                        capture          = 1'b1;
                    end
                end
                FUNC_REMOVE: begin
                    if (id_match && !tok_in.hit) begin
                        tok_next.hit = 1'b1;
                        valid_next   = 1'b0;
                    end
                end
                FUNC_CHECK: begin
                    if (pt_hit) begin
                        tok_next.hit = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        // Resolve a tentative add once the whole table has been searched
        if (bcast.done) begin
            if (pend_reg && bcast.commit) begin
                valid_next = 1'b1;
            end
            pend_next = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
            tok_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
            tok_reg   <= tok_next;
        end
    end

    // Advance the token payload and capture a new rectangle
    always_ff @(posedge aclk) begin
        id_o_reg <= id_in;
        ax_o_reg <= ax_in;
        az_o_reg <= az_in;
        bx_o_reg <= bx_in;
        bz_o_reg <= bz_in;
        if (capture) begin
            id_reg      <= id_in;
            left_x_reg  <= ax_in;
            near_z_reg  <= az_in;
            right_x_reg <= bx_in;
            far_z_reg   <= bz_in;
        end
    end

    assign tok_out = tok_reg;
    assign id_out  = id_o_reg;
    assign ax_out  = ax_o_reg;
    assign az_out  = az_o_reg;
    assign bx_out  = bx_o_reg;
    assign bz_out  = bz_o_reg;

    `BTHIT_ASSERT_NOW(a_cell_no_pend_and_valid, aclk, aresetn, pend_reg, !valid_reg)
    `BTHIT_ASSERT_NEXT(a_cell_pend_cleared, aclk, aresetn, bcast.done, !pend_reg)
    `BTHIT_ASSERT_NEXT(a_cell_commit_sets_valid, aclk, aresetn,
        bcast.done && bcast.commit && pend_reg, valid_reg)

endmodule

>>> src/bthit_resq.sv
// Two-entry result queue that decouples the cell chain from the result channel.
// Depends on bthit_pkg; instantiated by the top level.
module bthit_resq (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    input  bthit_pkg::res_t push_res,
    input  logic            m_ready,
    output logic            m_valid,
    output bthit_pkg::res_t m_res,
    output logic            skid_busy
);
    import bthit_pkg::*;

    logic head_valid_reg, head_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t head_reg, head_next;
    res_t skid_reg, skid_next;
    logic pop;

    assign pop = head_valid_reg && m_ready;

    // Shift the skid entry forward on a pop; a new item goes to the first free entry
    always_comb begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                head_next       = skid_reg;
                skid_valid_next = push_valid;
                skid_next       = push_res;
            end else begin
                head_valid_next = push_valid;
                head_next       = push_res;
            end
        end else if (push_valid) begin
            if (!head_valid_reg) begin
                head_valid_next = 1'b1;
                head_next       = push_res;
            end else begin
                skid_valid_next = 1'b1;
                skid_next       = push_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign m_valid   = head_valid_reg;
    assign m_res     = head_reg;
    assign skid_busy = skid_valid_reg;

endmodule

>>> src/box_table_point_hit_test_unit.sv
// Top level of the box table point hit test unit: input stage, cell chain, result queue.
// Depends on bthit_pkg, bthit_cell, bthit_resq and the assertion macro header.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+---------------------------------------------
//   s_      | in  | s_valid / s_ready  | func, object_id, box_x/z, extent_x/z, point_x/z
//   m_      | out | m_valid / m_ready  | answer_flag, full_error
//
// An item walks the chain of MAX_BOXES cells, one cell per cycle; the next item is
// taken only once the result of the last one has entered the queue, so the unit does
// not overlap items and the chain length sets the throughput.
// Synchronous active-low reset empties the table at once; no clearing pass.
// A stalled result channel holds up to two results; input stalls while an item is in the chain or both are used.
`include "box_table_point_hit_test_unit_macros.svh"

module box_table_point_hit_test_unit #(
    parameter int MAX_BOXES   = 64,
    parameter int COORD_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [15:0] s_object_id,
    input  logic signed [31:0] s_box_x,
    input  logic signed [31:0] s_box_z,
    input  logic signed [31:0] s_extent_x,
    input  logic signed [31:0] s_extent_z,
    input  logic signed [31:0] s_point_x,
    input  logic signed [31:0] s_point_z,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_answer_flag,
    output logic        m_full_error
);
    import bthit_pkg::*;

    localparam int CB = (COORD_WIDTH < IN_COORD_W) ? COORD_WIDTH : IN_COORD_W;

    // Chain links; link 0 is the input stage, link MAX_BOXES the chain end
    tok_ctl_t                 tok_w [MAX_BOXES+1];
    logic [ID_W-1:0]          id_w  [MAX_BOXES+1];
    logic signed [CB-1:0]     ax_w  [MAX_BOXES+1];
    logic signed [CB-1:0]     az_w  [MAX_BOXES+1];
    logic signed [CB:0]       bx_w  [MAX_BOXES+1];
    logic signed [CB:0]       bz_w  [MAX_BOXES+1];
    logic [MAX_BOXES:0]       tok_vld_vec;

    logic                     busy_reg, busy_next;
    tok_ctl_t                 inj_tok_reg, inj_tok_next;
    logic [ID_W-1:0]          inj_id_reg;
    logic signed [CB-1:0]     inj_ax_reg, inj_az_reg;
    logic signed [CB:0]       inj_bx_reg, inj_bz_reg;

    logic                     s_fire, skid_busy, chain_done;
    logic signed [CB-1:0]     box_x_c, box_z_c, ext_x_c, ext_z_c, pt_x_c, pt_z_c;
    tok_ctl_t                 tok_end;
    bcast_t                   bcast;
    res_t                     res, m_res;

    assign s_ready = !busy_reg && !skid_busy;
    assign s_fire  = s_valid && s_ready;

    // Take the low coordinate bits as signed values
    assign box_x_c = s_box_x[CB-1:0];
    assign box_z_c = s_box_z[CB-1:0];
    assign ext_x_c = s_extent_x[CB-1:0];
    assign ext_z_c = s_extent_z[CB-1:0];
    assign pt_x_c  = s_point_x[CB-1:0];
    assign pt_z_c  = s_point_z[CB-1:0];

    // Build the token for an accepted item
    always_comb begin
        inj_tok_next       = '0;
        busy_next          = busy_reg;
        if (s_fire) begin
            inj_tok_next.valid = 1'b1;
            inj_tok_next.func  = s_func;
            busy_next          = 1'b1;
        end else if (chain_done) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            inj_tok_reg <= '0;
        end else begin
            busy_reg    <= busy_next;
            inj_tok_reg <= inj_tok_next;
        end
    end

    // Capture payload; add carries corner and far edge, check carries the point
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            inj_id_reg <= s_object_id;
            if (s_func == FUNC_CHECK) begin
                inj_ax_reg <= pt_x_c;
                inj_az_reg <= pt_z_c;
            end else begin
                inj_ax_reg <= box_x_c;
                inj_az_reg <= box_z_c;
            end
            inj_bx_reg <= {box_x_c[CB-1], box_x_c} + {ext_x_c[CB-1], ext_x_c};
            inj_bz_reg <= {box_z_c[CB-1], box_z_c} + {ext_z_c[CB-1], ext_z_c};
        end
    end

    assign tok_w[0] = inj_tok_reg;
    assign id_w[0]  = inj_id_reg;
    assign ax_w[0]  = inj_ax_reg;
    assign az_w[0]  = inj_az_reg;
    assign bx_w[0]  = inj_bx_reg;
    assign bz_w[0]  = inj_bz_reg;

    // Row of entry cells
    for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
        bthit_cell #(
            .COORD_BITS (CB)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_in  (tok_w[i]),
            .id_in   (id_w[i]),
            .ax_in   (ax_w[i]),
            .az_in   (az_w[i]),
            .bx_in   (bx_w[i]),
            .bz_in   (bz_w[i]),
            .bcast   (bcast),
            .tok_out (tok_w[i+1]),
            .id_out  (id_w[i+1]),
            .ax_out  (ax_w[i+1]),
            .az_out  (az_w[i+1]),
            .bx_out  (bx_w[i+1]),
            .bz_out  (bz_w[i+1])
        );
    end

    for (genvar j = 0; j <= MAX_BOXES; j++) begin : g_vld
        assign tok_vld_vec[j] = tok_w[j].valid;
    end

    // Turn the token at the chain end into a result and a commit decision
    assign tok_end    = tok_w[MAX_BOXES];
    assign chain_done = tok_end.valid;

    always_comb begin
        res          = '0;
        bcast.done   = chain_done;
        bcast.commit = 1'b0;
        unique case (tok_end.func)
            FUNC_ADD: begin
                res.flag     = tok_end.hit;
                res.full     = !tok_end.hit && !tok_end.claimed;
                bcast.commit = chain_done && !tok_end.hit;
            end
            FUNC_REMOVE: res.flag = !tok_end.hit;
            FUNC_CHECK:  res.flag = tok_end.hit;
            default: begin
            end
        endcase
    end

    bthit_resq u_resq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (chain_done),
        .push_res   (res),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .m_res      (m_res),
        .skid_busy  (skid_busy)
    );

    assign m_answer_flag = m_res.flag;
    assign m_full_error  = m_res.full;

    `BTHIT_ASSERT_NOW(a_one_token, aclk, aresetn, 1'b1, $onehot0(tok_vld_vec))
    `BTHIT_ASSERT_NOW(a_idle_chain_empty, aclk, aresetn, !busy_reg, tok_vld_vec == '0)
    `BTHIT_ASSERT_NEXT(a_accept_injects, aclk, aresetn, s_fire, tok_vld_vec[0] && busy_reg)
    `BTHIT_ASSERT_NOW(a_full_not_claimed, aclk, aresetn, chain_done && res.full,
        !tok_end.claimed && (tok_end.func == FUNC_ADD))

endmodule

>>> test/tb_box_table_point_hit_test_unit.sv
// Self-checking testbench for box_table_point_hit_test_unit: add, remove and point checks
// against a behavioral rectangle table. Depends on bthit_pkg and the unit's RTL only.
module tb_box_table_point_hit_test_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bthit_pkg::*;

    localparam int MAX_BOXES    = 64;
    localparam int RANDOM_ITEMS = 1300;
    localparam int MAX_REPORTS  = 10;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;

    typedef enum int {PH_MIXED, PH_FILL, PH_DRAIN} load_phase_e;

    // One input item, plus a hand-written result where it is obvious
    typedef struct {
        logic [FUNC_W-1:0]  func;
        logic [ID_W-1:0]    id;
        logic signed [31:0] bx;
        logic signed [31:0] bz;
        logic signed [31:0] ex;
        logic signed [31:0] ez;
        logic signed [31:0] px;
        logic signed [31:0] pz;
        bit                 typed;
        bit                 exp_flag;
        bit                 exp_full;
    } hit_op_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_func;
    logic [15:0]        s_object_id;
    logic signed [31:0] s_box_x;
    logic signed [31:0] s_box_z;
    logic signed [31:0] s_extent_x;
    logic signed [31:0] s_extent_z;
    logic signed [31:0] s_point_x;
    logic signed [31:0] s_point_z;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_answer_flag;
    logic               m_full_error;

    // Shadow copy of the rectangle table
    bit          box_live  [MAX_BOXES];
    logic [15:0] box_key   [MAX_BOXES];
    longint      box_left  [MAX_BOXES];
    longint      box_near  [MAX_BOXES];
    longint      box_width [MAX_BOXES];
    longint      box_depth [MAX_BOXES];

    res_t expected_q [$];
    int   error_cnt = 0;
    int   burst_left = 0;
    int   ready_mode = 0;
    int   ready_hold = 0;
    int   cycle_cnt = 0;

    // Directed items: edges, extremes, every operation and each corner case
    hit_op_t directed_ops [25] = '{
        '{FUNC_CHECK,  16'h0000, 0, 0, 0, 0, 0, 0,                1'b1, 1'b0, 1'b0},
        '{FUNC_CHECK,  16'h0000, 0, 0, 0, 0, C_MIN, C_MAX,        1'b1, 1'b0, 1'b0},
        '{FUNC_REMOVE, 16'h0005, 0, 0, 0, 0, 0, 0,                1'b1, 1'b1, 1'b0},
        '{FUNC_UNUSED, 16'hFFFF, -1, -1, -1, -1, -1, -1,          1'b1, 1'b0, 1'b0},
        '{FUNC_ADD,    16'hFFFF, C_MIN, C_MIN, C_MAX, C_MAX, 0, 0, 1'b1, 1'b0, 1'b0},
        '{FUNC_ADD,    16'hFFFF, 0, 0, 100, 100, 0, 0,            1'b1, 1'b1, 1'b0},
        '{FUNC_CHECK,  16'h0000, 0, 0, 0, 0, C_MIN, C_MIN,        1'b0, 1'b0, 1'b0},
        '{FUNC_CHECK,  16'h0000, 0, 0, 0, 0, -2, -2,              1'b0, 1'b0, 1'b0},
        '{FUNC_CHECK,  16'h0000, 0, 0, 0, 0, -1, 0,               1'b0, 1'b0, 1'b0},
        '{FUNC_REMOVE, 16'hFFFF, 0, 0, 0, 0, 0, 0,                1'b1, 1'b0, 1'b0},
        '{FUNC_REMOVE, 16'hFFFF, 0, 0, 0, 0, 0, 0,                1'b1, 1'b1, 1'b0},
        '{FUNC_ADD,    16'h0000, 32'sh4000_0000, 32'sh4000_0000, C_MAX, C_MAX, 0, 0,
                                                                  1'b1, 1'b0, 1'b0},
        '{FUNC_CHECK,  16'h0000, 0, 0, 0, 0, C_MAX, C_MAX,        1'b0, 1'b0, 1'b0},
        '{FUNC_CHECK,  16'h0000, 0, 0, 0, 0, 32'sh4000_0000, C_MAX, 1'b0, 1'b0, 1'b0},
        '{FUNC_ADD,    16'h0001, 0, 0, 0, 32'sh1000, 0, 0,        1'b1, 1'b0, 1'b0},
        '{FUNC_ADD,    16'h0002, 0, 0, -32'sh1000, 32'sh1000, 0, 0, 1'b1, 1'b0, 1'b0},
        '{FUNC_ADD,    16'h0003, C_MAX, C_MIN, C_MIN, C_MIN, 0, 0, 1'b1, 1'b0, 1'b0},
        '{FUNC_CHECK,  16'h0000, 0, 0, 0, 0, 0, 32'sh800,         1'b0, 1'b0, 1'b0},
        '{FUNC_CHECK,  16'h0000, 0, 0, 0, 0, -32'sh800, 32'sh800, 1'b0, 1'b0, 1'b0},
        '{FUNC_ADD,    16'h0004, -32'sh100, -32'sh100, 32'sh200, 32'sh200, 0, 0,
                                                                  1'b1, 1'b0, 1'b0},
        '{FUNC_CHECK,  16'h0000, 0, 0, 0, 0, 0, 0,                1'b0, 1'b0, 1'b0},
        '{FUNC_CHECK,  16'h0000, 0, 0, 0, 0, -32'sh100, 0,        1'b0, 1'b0, 1'b0},
        '{FUNC_CHECK,  16'h0000, 0, 0, 0, 0, 32'sh100, 0,         1'b0, 1'b0, 1'b0},
        '{FUNC_UNUSED, 16'h0004, 0, 0, 0, 0, 0, 0,                1'b1, 1'b0, 1'b0},
        '{FUNC_REMOVE, 16'h0004, 0, 0, 0, 0, 0, 0,                1'b1, 1'b0, 1'b0}
    };

    box_table_point_hit_test_unit #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_WIDTH(32)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_object_id  (s_object_id),
        .s_box_x      (s_box_x),
        .s_box_z      (s_box_z),
        .s_extent_x   (s_extent_x),
        .s_extent_z   (s_extent_z),
        .s_point_x    (s_point_x),
        .s_point_z    (s_point_z),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_answer_flag(m_answer_flag),
        .m_full_error (m_full_error)
    );

    always #5 aclk = ~aclk;

    function automatic int lookup_box(input logic [15:0] key);
        for (int i = 0; i < MAX_BOXES; i++)
            if (box_live[i] && box_key[i] == key) return i;
        return -1;
    endfunction

    function automatic int random_live_slot();
        int live_idx [$];
        for (int i = 0; i < MAX_BOXES; i++)
            if (box_live[i]) live_idx = {live_idx, i};
        if (live_idx.size() == 0) return -1;
        return live_idx[$urandom_range(0, live_idx.size() - 1)];
    endfunction

    // Apply one item to the shadow table and compute its result
    task automatic apply_op(input hit_op_t op, output res_t r);
        int     slot;
        longint qx;
        longint qz;
        r = '0;
        qx = longint'(op.px);
        qz = longint'(op.pz);
        case (op.func)
            FUNC_ADD: begin
                slot = lookup_box(op.id);
                if (slot >= 0) begin
                    r.flag = 1'b1;
                end else begin
                    for (int i = 0; i < MAX_BOXES && slot < 0; i++)
                        if (!box_live[i]) slot = i;
                    if (slot < 0) begin
                        r.full = 1'b1;
                    end else begin
                        box_live[slot]  = 1'b1;
                        box_key[slot]   = op.id;
                        box_left[slot]  = longint'(op.bx);
                        box_near[slot]  = longint'(op.bz);
                        box_width[slot] = longint'(op.ex);
                        box_depth[slot] = longint'(op.ez);
                    end
                end
            end
            FUNC_REMOVE: begin
                slot = lookup_box(op.id);
                if (slot < 0) r.flag = 1'b1;
                else box_live[slot] = 1'b0;
            end
            FUNC_CHECK: begin
                // strict inside test, sums are wide enough not to wrap
                for (int i = 0; i < MAX_BOXES; i++)
                    if (box_live[i] && box_left[i] < qx && box_left[i] + box_width[i] > qx &&
                        box_near[i] < qz && box_near[i] + box_depth[i] > qz)
                        r.flag = 1'b1;
            end
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_coord();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) return $urandom();
        if (pick < 22) begin
            case ($urandom_range(0, 3))
                0: return C_MIN;
                1: return C_MAX;
                2: return 32'h0;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return 32'((int'($urandom_range(0, 8000)) - 4000) * 4096);
    endfunction

    function automatic logic [31:0] rand_size();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) return 32'(-int'($urandom_range(0, 4096)));
        if (pick < 14) return $urandom();
        if (pick < 17) return ($urandom_range(0, 1) != 0) ? C_MAX : C_MIN;
        return 32'(int'($urandom_range(1, 6000)) * 4096);
    endfunction

    function automatic logic [15:0] pick_key(input int unsigned present_pct);
        int          slot;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        slot = random_live_slot();
        if (pick < present_pct && slot >= 0) return box_key[slot];
        if (pick < 95) return 16'($urandom_range(0, 127));
        return 16'($urandom());
    endfunction

    // Aim one axis of a query at a stored rectangle: mostly inside, sometimes on an edge or just outside
    function automatic logic [31:0] near_coord(input longint base, input longint span);
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 7 && span >= 2) return 32'(base + longint'($urandom_range(32'(span - 1), 1)));
        if (pick == 7) return 32'(base);
        if (pick == 8) return 32'(base + span);
        return ($urandom_range(0, 1) != 0) ? 32'(base + span + 1) : 32'(base - 1);
    endfunction

    function automatic hit_op_t make_random_op(input load_phase_e kind);
        hit_op_t     op;
        int unsigned pick;
        int          slot;
        op.bx = rand_coord();
        op.bz = rand_coord();
        op.ex = rand_size();
        op.ez = rand_size();
        op.px = rand_coord();
        op.pz = rand_coord();
        op.typed = 1'b0;
        op.exp_flag = 1'b0;
        op.exp_full = 1'b0;
        op.id = 16'($urandom());
        pick = $urandom_range(0, 99);
        case (kind)
            PH_FILL:  op.func = (pick < 70) ? FUNC_ADD : (pick < 75) ? FUNC_REMOVE :
                                (pick < 98) ? FUNC_CHECK : FUNC_UNUSED;
            PH_DRAIN: op.func = (pick < 10) ? FUNC_ADD : (pick < 65) ? FUNC_REMOVE :
                                (pick < 98) ? FUNC_CHECK : FUNC_UNUSED;
            default:  op.func = (pick < 35) ? FUNC_ADD : (pick < 60) ? FUNC_REMOVE :
                                (pick < 97) ? FUNC_CHECK : FUNC_UNUSED;
        endcase
        if (op.func == FUNC_ADD) op.id = pick_key((kind == PH_FILL) ? 10 : 25);
        if (op.func == FUNC_REMOVE) op.id = pick_key(70);
        if (op.func == FUNC_CHECK && $urandom_range(0, 99) < 60) begin
            slot = random_live_slot();
            if (slot >= 0) begin
                op.px = near_coord(box_left[slot], box_width[slot]);
                op.pz = near_coord(box_near[slot], box_depth[slot]);
            end
        end
        return op;
    endfunction

    // Drive one item, hold it until taken, then record its result and maybe go idle
    task automatic send_op(input hit_op_t op);
        res_t        predicted;
        res_t        want_res;
        int unsigned pick;
        int          gap;
        s_valid     <= 1'b1;
        s_func      <= op.func;
        s_object_id <= op.id;
        s_box_x     <= op.bx;
        s_box_z     <= op.bz;
        s_extent_x  <= op.ex;
        s_extent_z  <= op.ez;
        s_point_x   <= op.px;
        s_point_z   <= op.pz;
        do @(posedge aclk); while (!s_ready);
        apply_op(op, predicted);
        if (op.typed) want_res = '{flag: op.exp_flag, full: op.exp_full};
        else want_res = predicted;
        expected_q = {expected_q, want_res};
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 30);
            pick = $urandom_range(0, 99);
            gap = (pick < 30) ? 0 : (pick < 80) ? $urandom_range(1, 20) : $urandom_range(21, 90);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Stop sending until every outstanding result is back
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    task automatic log_error(input string msg);
        if (error_cnt < MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, msg);
        error_cnt++;
    endtask

    // Result receiver: pick a random stall pattern and keep it until a hold counter runs out
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (ready_hold == 0) begin
            ready_mode <= $urandom_range(0, 3);
            ready_hold <= $urandom_range(50, 400);
        end else begin
            ready_hold <= ready_hold - 1;
        end
        case (ready_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= ((cycle_cnt % 9) < 4);
        endcase
    end

    // Compare each taken result with the oldest prediction
    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                log_error($sformatf("result with none pending: flag=%0b full=%0b",
                                    m_answer_flag, m_full_error));
            end else begin
                want = expected_q.pop_front();
                if (m_answer_flag !== want.flag || m_full_error !== want.full)
                    log_error($sformatf("flag exp %0b got %0b, full exp %0b got %0b",
                                        want.flag, m_answer_flag, want.full, m_full_error));
            end
        end
    end

    // Stimulus: reset, directed items, then phases of random traffic
    initial begin
        int          sent;
        int          phase_len;
        load_phase_e kind;
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_func      <= '0;
        s_object_id <= '0;
        s_box_x     <= '0;
        s_box_z     <= '0;
        s_extent_x  <= '0;
        s_extent_z  <= '0;
        s_point_x   <= '0;
        s_point_z   <= '0;
        foreach (box_live[i]) box_live[i] = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_ops[i]) send_op(directed_ops[i]);
        settle();

        // start with a fill phase so the table reaches capacity early
        sent = 0;
        kind = PH_FILL;
        while (sent < RANDOM_ITEMS) begin
            phase_len = (kind == PH_FILL) ? $urandom_range(150, 220) : $urandom_range(40, 160);
            for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
                send_op(make_random_op(kind));
                sent++;
            end
            if (kind == PH_FILL || $urandom_range(0, 1) != 0) settle();
            kind = load_phase_e'($urandom_range(0, 2));
        end

        // drain, then watch for stray results
        settle();
        repeat (MAX_BOXES + 4) @(posedge aclk);
        if (error_cnt == 0 && expected_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("Timeout with %0d results outstanding", expected_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
